[hdl/hdp_pkg.sv]
package hdp_pkg;

    localparam int DEF_WINDOW_TAPS = 8;
    localparam int DEF_HIST_BINS   = 101;
    localparam int DEF_DELAY_TAPS  = 25;

    localparam int SUM_W    = 20;
    localparam int DIFF_W   = 21;
    localparam int BIN_W    = 24;
    localparam int WORD_W   = 32;
    localparam int THR_W    = 20;
    localparam int LVL_W    = 12;
    localparam int SCOPE_W  = 24;
    localparam int CFG_W    = 20;
    localparam int CFG_IDX_W = 2;

    localparam int RST_THRESH = 5000;
    localparam int RST_ARM    = 16;
    localparam int RST_REL    = 8;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    localparam t_cfg_idx CFG_THRESH  = 2'd0;
    localparam t_cfg_idx CFG_ARM     = 2'd1;
    localparam t_cfg_idx CFG_RELEASE = 2'd2;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_PEAK,
        ST_DIVST,
        ST_DIV,
        ST_CORR,
        ST_FIN
    } t_state;

endpackage

[hdl/hdp_in_if.sv]
interface hdp_in_if;
    logic                       valid;
    logic                       ready;
    logic [hdp_pkg::SUM_W-1:0]  sample_sum;
    logic                       clear_req;
    logic                       detection_on;
    logic                       suppressed;

    modport source (output valid, sample_sum, clear_req, detection_on, suppressed,
                    input ready);
    modport sink (input valid, sample_sum, clear_req, detection_on, suppressed,
                  output ready);
endinterface

[hdl/hdp_out_if.sv]
interface hdp_out_if;
    logic                               valid;
    logic                               ready;
    logic                               pulse_found;
    logic [hdp_pkg::WORD_W-1:0]         pulse_count;
    logic signed [hdp_pkg::SCOPE_W-1:0] scope_level;

    modport source (output valid, pulse_found, pulse_count, scope_level, input ready);
    modport sink (input valid, pulse_found, pulse_count, scope_level, output ready);
endinterface

[hdl/hdp_ram.sv]
module hdp_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 101
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

[hdl/hdp_div.sv]
module hdp_div #(
    parameter int NW = 30,
    parameter int DW = 24
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic signed [NW-1:0] i_num,
    input  logic [DW-1:0]        i_den,
    output logic                 o_done,
    output logic signed [NW-1:0] o_quot
);
    localparam int CW = $clog2(NW + 1);

    logic          r_busy;
    logic          r_done;
    logic [CW-1:0] r_cnt;
    logic          r_neg;
    logic [NW-1:0] r_q;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_den;
    logic [DW:0]   w_rs;
    logic          w_ge;

    // one quotient bit per cycle, restoring on magnitudes
    assign w_rs = {r_rem, r_q[NW-1]};
    assign w_ge = (w_rs >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_neg  <= i_num[NW-1];
                r_q    <= i_num[NW-1] ? NW'(-i_num) : NW'(i_num);
                r_rem  <= '0;
                r_den  <= i_den;
            end else if (r_busy) begin
                r_rem <= w_ge ? DW'(w_rs - {1'b0, r_den}) : DW'(w_rs);
                r_q   <= {r_q[NW-2:0], w_ge};
                r_cnt <= r_cnt + CW'(1);
                if (r_cnt == CW'(NW - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_neg ? -$signed(r_q) : $signed(r_q);
endmodule

[hdl/histogram_drift_pulse_detector.sv]
// path: an input transaction starts a scan of the histogram ram (one bin a cycle); unless
//   the peak is near an edge, the peak bin and its neighbours are then read, and unless the
//   peak bin is not above zero the serial divider refines the peak before the result is
//   stored
// throughput: one item at a time, a new item is taken once the previous result is stored
// reset: after i_rst_n the rams are swept to zero, and during the sweep no input transaction is taken
module histogram_drift_pulse_detector #(
    parameter int WINDOW_TAPS = hdp_pkg::DEF_WINDOW_TAPS,
    parameter int HIST_BINS   = hdp_pkg::DEF_HIST_BINS,
    parameter int DELAY_TAPS  = hdp_pkg::DEF_DELAY_TAPS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [hdp_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [hdp_pkg::CFG_W-1:0]     i_cfg_data,
    hdp_in_if.sink                        i_item,
    hdp_out_if.source                     o_result
);
    import hdp_pkg::*;

    localparam int WP     = (WINDOW_TAPS > 1) ? $clog2(WINDOW_TAPS) : 1;
    localparam int TW     = DIFF_W + $clog2(WINDOW_TAPS);
    localparam int IW     = $clog2(HIST_BINS);
    localparam int DPW    = $clog2(DELAY_TAPS);
    localparam int SWEEP  = (HIST_BINS > DELAY_TAPS) ? HIST_BINS : DELAY_TAPS;
    localparam int SW     = $clog2(SWEEP);
    localparam int CENTER = HIST_BINS / 2;
    localparam int NUM_W  = BIN_W + 6;

    function automatic logic signed [SCOPE_W-1:0] div256(input logic [WORD_W-1:0] x);
        logic [WORD_W-1:0] q;
        q = $unsigned($signed(x) >>> 8);
        if (x[WORD_W-1] && (x[7:0] != 8'd0)) begin
            q = q + WORD_W'(1);
        end
        return $signed(q[SCOPE_W-1:0]);
    endfunction

    t_state r_state, n_state;

    logic [THR_W-1:0] r_thr;
    logic [LVL_W-1:0] r_arm;
    logic [LVL_W-1:0] r_rel;

    logic [SUM_W-1:0]         r_prev;
    logic signed [DIFF_W-1:0] r_win [WINDOW_TAPS];
    logic signed [TW-1:0]     r_total;
    logic [WP-1:0]            r_wptr;
    logic [WORD_W-1:0]        r_drift;
    logic [DPW-1:0]           r_dptr;
    logic                     r_armed;
    logic [WORD_W-1:0]        r_base;
    logic [WORD_W-1:0]        r_count;

    logic [SUM_W-1:0] r_sample;
    logic             r_clr;
    logic             r_det;
    logic             r_supp;

    logic                    r_binok;
    logic [IW-1:0]           r_wh;
    logic signed [5:0]       r_frac;
    logic [IW:0]             r_idx;
    logic                    r_sv;
    logic [IW-1:0]           r_sidx;
    logic signed [BIN_W-1:0] r_top;
    logic [IW-1:0]           r_peak;
    logic [1:0]              r_pk;
    logic signed [BIN_W-1:0] r_lo, r_mid, r_hi;
    logic [WORD_W-1:0]       r_corr;
    logic [SW-1:0]           r_sw;

    logic                      r_ov;
    logic                      r_of;
    logic [WORD_W-1:0]         r_oc;
    logic signed [SCOPE_W-1:0] r_os;

    // control strobes
    logic              w_in_ready;
    logic              w_bin_we;
    logic [IW-1:0]     w_bin_waddr;
    logic [BIN_W-1:0]  w_bin_wdata;
    logic [IW-1:0]     w_bin_raddr;
    logic [BIN_W-1:0]  w_bin_rdata;
    logic              w_dly_we;
    logic [DPW-1:0]    w_dly_waddr;
    logic [WORD_W-1:0] w_dly_wdata;
    logic [WORD_W-1:0] w_dly_rdata;
    logic              w_div_start;
    logic              w_div_done;
    logic signed [NUM_W-1:0] w_div_num;
    logic signed [NUM_W-1:0] w_div_quot;
    logic              w_out_free;

    // datapath
    logic                     w_clr_in;
    logic signed [DIFF_W-1:0] w_d;
    logic signed [DIFF_W-1:0] w_wold;
    logic signed [TW-1:0]     w_told;
    logic signed [TW-1:0]     w_ntotal;
    logic signed [TW-1:0]     w_q32;
    logic signed [TW-1:0]     w_frac_full;
    logic signed [TW:0]       w_whole;
    logic signed [BIN_W-1:0]  w_v0;
    logic signed [6:0]        w_add_a;
    logic signed [BIN_W-1:0]  w_v;
    logic signed [BIN_W-1:0]  w_dec;
    logic [IW-1:0]            w_pk_addr;
    logic                     w_pk_ok;
    logic signed [WORD_W-1:0] w_step;
    logic [WORD_W-1:0]        w_old;
    logic signed [SCOPE_W-1:0] w_hp;
    logic                     w_arm_now;
    logic                     w_armed_mid;
    logic [WORD_W-1:0]        w_base_mid;
    logic                     w_rel_now;
    logic signed [WORD_W-1:0] w_height;
    logic                     w_count_now;

    hdp_ram #(.WIDTH(BIN_W), .DEPTH(HIST_BINS)) u_bin_ram (
        .i_clk   (i_clk),
        .i_we    (w_bin_we),
        .i_waddr (w_bin_waddr),
        .i_wdata (w_bin_wdata),
        .i_raddr (w_bin_raddr),
        .o_rdata (w_bin_rdata)
    );

    hdp_ram #(.WIDTH(WORD_W), .DEPTH(DELAY_TAPS)) u_dly_ram (
        .i_clk   (i_clk),
        .i_we    (w_dly_we),
        .i_waddr (w_dly_waddr),
        .i_wdata (w_dly_wdata),
        .i_raddr (r_dptr),
        .o_rdata (w_dly_rdata)
    );

    hdp_div #(.NW(NUM_W), .DW(BIN_W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (r_mid),
        .o_done  (w_div_done),
        .o_quot  (w_div_quot)
    );

    assign w_out_free = !r_ov || o_result.ready;
    assign w_pk_ok    = (r_peak > IW'(2)) && (r_peak < IW'(HIST_BINS - 3));
    assign w_pk_addr  = r_peak + IW'(r_pk) - IW'(1);

    always_comb begin
        w_clr_in = i_item.clear_req || !i_item.detection_on;
        w_d      = $signed({1'b0, i_item.sample_sum}) - $signed({1'b0, r_prev});
        w_wold   = w_clr_in ? '0 : r_win[r_wptr];
        w_told   = w_clr_in ? '0 : r_total;
        w_ntotal = w_told + TW'(w_d) - TW'(w_wold);

        // truncating divide and remainder by 32
        w_q32 = r_total >>> 5;
        if (r_total[TW-1] && (r_total[4:0] != 5'd0)) begin
            w_q32 = w_q32 + TW'(1);
        end
        w_frac_full = r_total - (w_q32 <<< 5);
        w_whole     = (TW+1)'(w_q32) + (TW+1)'(CENTER);

        // bin update during the scan
        w_v0    = r_clr ? '0 : $signed(w_bin_rdata);
        w_add_a = 7'sd32 - 7'(r_frac);
        w_v     = w_v0;
        if (r_binok && (r_sidx == r_wh)) begin
            w_v = w_v + BIN_W'(w_add_a);
        end
        if (r_binok && (r_sidx == r_wh + IW'(1))) begin
            w_v = w_v + BIN_W'(r_frac);
        end
        w_dec = w_v >>> 7;
        if (w_v[BIN_W-1] && (w_v[6:0] != 7'd0)) begin
            w_dec = w_dec + BIN_W'(1);
        end
        w_dec = w_v - w_dec;

        w_div_num = NUM_W'((BIN_W+1)'(r_hi) - (BIN_W+1)'(r_lo)) <<< 5;
        w_step    = ((WORD_W'(r_peak) - WORD_W'(CENTER)) <<< 5) + WORD_W'(w_div_quot);

        // high-pass and hysteresis
        w_old       = w_dly_rdata;
        w_hp        = div256(r_corr - w_old);
        w_arm_now   = (w_hp > $signed({12'b0, r_arm})) && !r_armed;
        w_armed_mid = r_armed || w_arm_now;
        w_base_mid  = w_arm_now ? w_old : r_base;
        w_rel_now   = (w_hp < $signed({12'b0, r_rel})) && w_armed_mid;
        w_height    = $signed(r_corr - w_base_mid);
        w_count_now = w_rel_now && (w_height > $signed({12'b0, r_thr})) && !r_supp && r_det;
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_INIT:  if (r_sw == SW'(SWEEP - 1)) n_state = ST_IDLE;
            ST_IDLE:  if (i_item.valid) n_state = ST_PREP;
            ST_PREP:  n_state = ST_SCAN;
            ST_SCAN:  if (r_sv && (r_sidx == IW'(HIST_BINS - 1))) n_state = ST_PEAK;
            ST_PEAK: begin
                if (!w_pk_ok) n_state = ST_CORR;
                else if (r_pk == 2'd3) n_state = ST_DIVST;
            end
            ST_DIVST: n_state = (r_mid > 0) ? ST_DIV : ST_CORR;
            ST_DIV:   if (w_div_done) n_state = ST_CORR;
            ST_CORR:  n_state = ST_FIN;
            ST_FIN:   if (w_out_free) n_state = ST_IDLE;
            default:  n_state = ST_INIT;
        endcase
    end

    // control outputs
    always_comb begin
        w_in_ready  = 1'b0;
        w_bin_we    = 1'b0;
        w_bin_waddr = r_sidx;
        w_bin_wdata = w_dec;
        w_bin_raddr = r_idx[IW-1:0];
        w_dly_we    = 1'b0;
        w_dly_waddr = r_dptr;
        w_dly_wdata = r_corr;
        w_div_start = 1'b0;
        case (r_state)
            ST_INIT: begin
                w_bin_we    = (r_sw < SW'(HIST_BINS)) || (HIST_BINS >= SWEEP);
                w_bin_waddr = r_sw[IW-1:0];
                w_bin_wdata = '0;
                w_dly_we    = (r_sw < SW'(DELAY_TAPS)) || (DELAY_TAPS >= SWEEP);
                w_dly_waddr = r_sw[DPW-1:0];
                w_dly_wdata = '0;
            end
            ST_IDLE:  w_in_ready = 1'b1;
            ST_SCAN:  w_bin_we = r_sv;
            ST_PEAK:  w_bin_raddr = w_pk_addr;
            ST_DIVST: w_div_start = (r_mid > 0);
            ST_FIN:   w_dly_we = w_out_free;
            default: ;
        endcase
    end

    assign i_item.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
            r_thr   <= THR_W'(RST_THRESH);
            r_arm   <= LVL_W'(RST_ARM);
            r_rel   <= LVL_W'(RST_REL);
            r_prev  <= '0;
            for (int k = 0; k < WINDOW_TAPS; k++) r_win[k] <= '0;
            r_total <= '0;
            r_wptr  <= '0;
            r_drift <= '0;
            r_dptr  <= '0;
            r_armed <= 1'b0;
            r_base  <= '0;
            r_count <= '0;
            r_sw    <= '0;
            r_sv    <= 1'b0;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;

            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_THRESH:  r_thr <= i_cfg_data[THR_W-1:0];
                    CFG_ARM:     r_arm <= i_cfg_data[LVL_W-1:0];
                    CFG_RELEASE: r_rel <= i_cfg_data[LVL_W-1:0];
                    default: ;
                endcase
            end

            if ((r_state == ST_FIN) && w_out_free) begin
                r_ov <= 1'b1;
            end else if (o_result.valid && o_result.ready) begin
                r_ov <= 1'b0;
            end

            case (r_state)
                ST_INIT: r_sw <= r_sw + SW'(1);
                ST_IDLE: begin
                    if (i_item.valid) begin
                        r_sample <= i_item.sample_sum;
                        r_clr    <= w_clr_in;
                        r_det    <= i_item.detection_on;
                        r_supp   <= i_item.suppressed;
                        r_prev   <= i_item.sample_sum;
                        if (w_clr_in) begin
                            for (int k = 0; k < WINDOW_TAPS; k++) begin
                                r_win[k] <= (WP'(k) == r_wptr) ? w_d : '0;
                            end
                        end else begin
                            r_win[r_wptr] <= w_d;
                        end
                        r_total <= w_ntotal;
                        r_wptr  <= (r_wptr == WP'(WINDOW_TAPS - 1)) ? '0 : r_wptr + WP'(1);
                    end
                end
                ST_PREP: begin
                    r_binok <= (w_whole > 0) && (w_whole < (TW+1)'(HIST_BINS - 1));
                    r_wh    <= w_whole[IW-1:0];
                    r_frac  <= w_frac_full[5:0];
                    if (r_clr) r_drift <= '0;
                    r_idx   <= '0;
                    r_top   <= '0;
                    r_peak  <= '0;
                    r_pk    <= '0;
                end
                ST_SCAN: begin
                    r_sv   <= (r_idx < (IW+1)'(HIST_BINS));
                    r_sidx <= r_idx[IW-1:0];
                    if (r_idx < (IW+1)'(HIST_BINS)) r_idx <= r_idx + (IW+1)'(1);
                    if (r_sv && (w_v > r_top)) begin
                        r_top  <= w_v;
                        r_peak <= r_sidx;
                    end
                end
                ST_PEAK: begin
                    r_sv <= 1'b0;
                    r_pk <= r_pk + 2'd1;
                    case (r_pk)
                        2'd1:    r_lo  <= $signed(w_bin_rdata);
                        2'd2:    r_mid <= $signed(w_bin_rdata);
                        2'd3:    r_hi  <= $signed(w_bin_rdata);
                        default: ;
                    endcase
                end
                ST_DIV: begin
                    if (w_div_done) r_drift <= r_drift + $unsigned(w_step);
                end
                ST_CORR: begin
                    r_sv   <= 1'b0;
                    r_corr <= {9'b0, r_sample, 3'b0} - r_drift;
                end
                ST_FIN: begin
                    if (w_out_free) begin
                        r_armed <= w_armed_mid && !w_rel_now;
                        r_base  <= w_base_mid;
                        if (w_count_now) r_count <= r_count + WORD_W'(1);
                        r_dptr  <= (r_dptr == DPW'(DELAY_TAPS - 1)) ? '0 : r_dptr + DPW'(1);
                        r_of    <= w_count_now;
                        r_oc    <= w_count_now ? r_count + WORD_W'(1) : r_count;
                        r_os    <= div256(r_corr);
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_result.valid       = r_ov;
    assign o_result.pulse_found = r_of;
    assign o_result.pulse_count = r_oc;
    assign o_result.scope_level = r_os;
endmodule

[hdl/hdp_checker.sv]
module hdp_checker (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic                                out_found,
    input logic [hdp_pkg::WORD_W-1:0]          out_count,
    input logic signed [hdp_pkg::SCOPE_W-1:0]  out_scope
);
    // reset starts the clearing sweep: nothing taken, nothing shown
    a_reset: assert property (@(posedge i_clk) !i_rst_n |=> !out_valid && !in_ready)
        else $error("block not quiet after reset");

    // one item in flight at a time
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transaction taken while item in flight");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_found)
            && $stable(out_count) && $stable(out_scope))
        else $error("stalled result changed");
endmodule

bind histogram_drift_pulse_detector hdp_checker u_hdp_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .in_valid  (i_item.valid),
    .in_ready  (i_item.ready),
    .out_valid (o_result.valid),
    .out_ready (o_result.ready),
    .out_found (o_result.pulse_found),
    .out_count (o_result.pulse_count),
    .out_scope (o_result.scope_level)
);

[test/tb_top.sv]
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import hdp_pkg::*;

    localparam int       N_BINS      = DEF_HIST_BINS;
    localparam int       N_WIN       = DEF_WINDOW_TAPS;
    localparam int       N_DLY       = DEF_DELAY_TAPS;
    localparam int       SETTLE      = 160;
    localparam int       STALL_LIMIT = 4000;
    localparam t_cfg_idx CFG_SPARE   = 2'd3;

    typedef struct packed {
        logic [SUM_W-1:0] sample_sum;
        logic             clear_req;
        logic             detection_on;
        logic             suppressed;
    } t_sample;

    typedef struct packed {
        logic               pulse_found;
        logic [WORD_W-1:0]  pulse_count;
        logic [SCOPE_W-1:0] scope_level;
    } t_pulse_res;

    typedef struct {
        t_sample    smp;
        bit         typed;
        t_pulse_res res;
    } t_row;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CFG_W-1:0]     i_cfg_data;

    hdp_in_if  item_if ();
    hdp_out_if res_if ();

    histogram_drift_pulse_detector uut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_item     (item_if.sink),
        .o_result   (res_if.source)
    );

    // detector state mirror
    logic [THR_W-1:0]  thr_q;
    logic [LVL_W-1:0]  arm_q;
    logic [LVL_W-1:0]  rel_q;
    logic [SUM_W-1:0]  last_sum;
    int                win [N_WIN];
    int                win_total;
    int                win_pos;
    int                hist [N_BINS];
    logic [31:0]       drift;
    logic [31:0]       dline [N_DLY];
    int                dpos;
    bit                in_pulse;
    logic [31:0]       base_lvl;
    logic [31:0]       n_pulses;

    t_pulse_res expected_q [$];
    bit         failed;
    int         idle_cycles;
    int         n_results;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic t_pulse_res detect_step(t_sample s);
        t_pulse_res r;
        int         d, whole, frac, top, pk, lo, mid, hi, hp, height, stp;
        logic [31:0] corr, old;
        r = '0;
        if (s.clear_req || !s.detection_on) begin
            win_total = 0;
            drift = '0;
            foreach (win[k]) win[k] = 0;
            foreach (hist[k]) hist[k] = 0;
        end
        d = int'(s.sample_sum) - int'(last_sum);
        last_sum = s.sample_sum;
        win_total += d - win[win_pos];
        win[win_pos] = d;
        win_pos = (win_pos + 1) % N_WIN;
        whole = win_total / 32 + N_BINS / 2;
        frac = win_total % 32;
        if (whole > 0 && whole < N_BINS - 1) begin
            hist[whole] += 32 - frac;
            hist[whole + 1] += frac;
        end
        top = 0;
        pk = 0;
        for (int k = 0; k < N_BINS; k++) begin
            if (hist[k] > top) begin
                top = hist[k];
                pk = k;
            end
            hist[k] -= hist[k] / 128;
        end
        if (pk > 2 && pk < N_BINS - 3) begin
            lo = hist[pk - 1];
            mid = hist[pk];
            hi = hist[pk + 1];
            if (mid > 0) begin
                stp = (pk - N_BINS / 2) * 32 + ((hi - lo) * 32) / mid;
                drift += stp;
            end
        end
        corr = {12'd0, s.sample_sum} * 8 - drift;
        old = dline[dpos];
        hp = $signed(corr - old) / 256;
        if (hp > int'(arm_q) && !in_pulse) begin
            base_lvl = old;
            in_pulse = 1'b1;
        end
        if (hp < int'(rel_q) && in_pulse) begin
            height = $signed(corr - base_lvl);
            in_pulse = 1'b0;
            if (height > int'(thr_q) && !s.suppressed && s.detection_on) begin
                n_pulses++;
                r.pulse_found = 1'b1;
            end
        end
        dline[dpos] = corr;
        dpos = (dpos + 1) % N_DLY;
        r.pulse_count = n_pulses;
        r.scope_level = 24'($signed(corr) / 256);
        return r;
    endfunction

    task automatic write_reg(t_cfg_idx idx, logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_idx = idx;
        i_cfg_data = val;
        case (idx)
            CFG_THRESH:  thr_q = val[THR_W-1:0];
            CFG_ARM:     arm_q = val[LVL_W-1:0];
            CFG_RELEASE: rel_q = val[LVL_W-1:0];
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_levels(logic [CFG_W-1:0] thr, logic [CFG_W-1:0] arm,
                              logic [CFG_W-1:0] rel);
        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        write_reg(CFG_THRESH, thr);
        write_reg(CFG_ARM, arm);
        write_reg(CFG_RELEASE, rel);
    endtask

    // called at a falling edge; returns at a falling edge once the sample is accepted
    task automatic send_sample(t_sample s, bit typed, t_pulse_res res);
        t_pulse_res pred;
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item_if.valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        item_if.valid = 1'b1;
        item_if.sample_sum = s.sample_sum;
        item_if.clear_req = s.clear_req;
        item_if.detection_on = s.detection_on;
        item_if.suppressed = s.suppressed;
        do @(posedge i_clk); while (!item_if.ready);
        pred = detect_step(s);
        expected_q.push_back(typed ? res : pred);
        @(negedge i_clk);
    endtask

    task automatic send_plain(logic [SUM_W-1:0] v, bit clr, bit det, bit sup);
        t_sample s;
        s = '{sample_sum: v, clear_req: clr, detection_on: det, suppressed: sup};
        send_sample(s, 1'b0, '0);
    endtask

    task automatic idle_input();
        item_if.valid = 1'b0;
    endtask

    // mostly well formed pulses on a random baseline, with noise around them
    task automatic random_phase(int n_items);
        int sent, lvl, amp, len;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 9))
                0: begin
                    send_plain(SUM_W'($urandom), $urandom_range(0, 15) == 0,
                               $urandom_range(0, 7) != 0, $urandom_range(0, 1));
                    sent++;
                end
                1: begin
                    send_plain(SUM_W'($urandom_range(0, 1) ? 0 : 20'hFFFFF),
                               1'b0, 1'b1, 1'b0);
                    sent++;
                end
                default: begin
                    lvl = $urandom_range(0, 600000);
                    amp = $urandom_range(0, 1) ? $urandom_range(0, 3000)
                                               : $urandom_range(0, 400000);
                    len = $urandom_range(1, 30);
                    repeat ($urandom_range(5, 30)) begin
                        send_plain(SUM_W'(lvl + $urandom_range(0, 40)),
                                   $urandom_range(0, 60) == 0,
                                   $urandom_range(0, 40) != 0, 1'b0);
                        sent++;
                    end
                    repeat (len) begin
                        send_plain(SUM_W'(lvl + amp + $urandom_range(0, 40)), 1'b0,
                                   1'b1, $urandom_range(0, 9) == 0);
                        sent++;
                    end
                end
            endcase
        end
        idle_input();
    endtask

    t_row rows [$];

    task automatic add_row(logic [SUM_W-1:0] v, bit clr, bit det, bit sup, bit typed,
                           t_pulse_res res);
        t_row r;
        r.smp = '{sample_sum: v, clear_req: clr, detection_on: det, suppressed: sup};
        r.typed = typed;
        r.res = res;
        rows.push_back(r);
    endtask

    // result checker
    initial begin
        t_pulse_res want;
        int stall;
        res_if.ready = 1'b0;
        n_results = 0;
        forever begin
            stall = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 14);
            @(negedge i_clk);
            if (stall > 0) begin
                res_if.ready = 1'b0;
                repeat (stall - 1) @(negedge i_clk);
                @(negedge i_clk);
            end
            res_if.ready = 1'b1;
            do @(posedge i_clk); while (!res_if.valid);
            n_results++;
            if (expected_q.size() == 0) begin
                $error("result transaction with nothing expected");
                failed = 1'b1;
            end else begin
                want = expected_q.pop_front();
                if (res_if.pulse_found !== want.pulse_found) begin
                    $error("pulse_found exp %0d got %0d", want.pulse_found,
                           res_if.pulse_found);
                    failed = 1'b1;
                end
                if (res_if.pulse_count !== want.pulse_count) begin
                    $error("pulse_count exp %0d got %0d", want.pulse_count,
                           res_if.pulse_count);
                    failed = 1'b1;
                end
                if (res_if.scope_level !== want.scope_level) begin
                    $error("scope_level exp %0d got %0d", $signed(want.scope_level),
                           res_if.scope_level);
                    failed = 1'b1;
                end
            end
        end
    end

    // watchdog on transactions
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("FAIL");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        failed = 1'b0;
        idle_cycles = 0;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_idx = CFG_THRESH;
        i_cfg_data = '0;
        item_if.valid = 1'b0;
        item_if.sample_sum = '0;
        item_if.clear_req = 1'b0;
        item_if.detection_on = 1'b0;
        item_if.suppressed = 1'b0;
        thr_q = THR_W'(RST_THRESH);
        arm_q = LVL_W'(RST_ARM);
        rel_q = LVL_W'(RST_REL);
        last_sum = '0;
        foreach (win[k]) win[k] = 0;
        win_total = 0;
        win_pos = 0;
        foreach (hist[k]) hist[k] = 0;
        drift = '0;
        foreach (dline[k]) dline[k] = '0;
        dpos = 0;
        in_pulse = 1'b0;
        base_lvl = '0;
        n_pulses = '0;

        // first rows start from reset: no drift, so the level is the scaled input
        add_row(20'd0, 1'b0, 1'b1, 1'b0, 1'b1, '0);
        add_row(20'hFFFFF, 1'b0, 1'b1, 1'b0, 1'b1,
                '{pulse_found: 1'b0, pulse_count: '0, scope_level: 24'd32767});
        add_row(20'd0, 1'b0, 1'b1, 1'b0, 1'b1, '0);
        for (int k = 0; k < 6; k++) add_row(20'd1000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        for (int k = 0; k < 3; k++) add_row(20'd9000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd1000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd9000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd1000, 1'b0, 1'b1, 1'b1, 1'b0, '0);
        add_row(20'd9000, 1'b1, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd1000, 1'b0, 1'b0, 1'b0, 1'b0, '0);
        add_row(20'd9000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd1000, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'hAAAAA, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'h55555, 1'b0, 1'b1, 1'b0, 1'b0, '0);
        add_row(20'd1, 1'b1, 1'b0, 1'b1, 1'b0, '0);

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // spare index must leave everything alone
        write_reg(CFG_SPARE, 20'hFFFFF);
        write_reg(CFG_THRESH, 20'(RST_THRESH));
        write_reg(CFG_ARM, 20'(RST_ARM));
        write_reg(CFG_RELEASE, 20'(RST_REL));
        foreach (rows[k]) send_sample(rows[k].smp, rows[k].typed, rows[k].res);
        idle_input();

        set_levels(20'd0, 20'd0, 20'd0);
        random_phase(230);
        set_levels(20'hFFFFF, 20'hFFF, 20'hFFF);
        random_phase(230);
        set_levels(20'd20000, 20'd40, 20'd4);
        random_phase(230);
        set_levels(20'(RST_THRESH), 20'(RST_ARM), 20'(RST_REL));
        random_phase(230);
        set_levels(20'd100, 20'd2, 20'd300);
        random_phase(210);

        wait (expected_q.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (!failed) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule
